[sv/utt_pkg.sv]
// Shared types, constants and the byte-formatting function for the UTF-16 to UTF-8 block.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none
package utt_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned CpW    = 21;
  localparam int unsigned LowW   = 10;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [UnitW-1:0] SurrLo    = 16'hd800;
  localparam logic [UnitW-1:0] SurrHi    = 16'hdfff;
  localparam logic [10:0]      PlaneOfs  = 11'h040;
  localparam logic [CpW-1:0]   Lim1Byte  = 21'h000080;
  localparam logic [CpW-1:0]   Lim2Byte  = 21'h000800;
  localparam logic [CpW-1:0]   Lim3Byte  = 21'h010000;

  // Sequence length, stored as byte count minus one.
  localparam logic [1:0] Len1 = 2'd0;
  localparam logic [1:0] Len2 = 2'd1;
  localparam logic [1:0] Len3 = 2'd2;
  localparam logic [1:0] Len4 = 2'd3;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic [1:0]     n;    // last byte index
    logic           fin;
  } cp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Byte i of the UTF-8 sequence for cp, whose last byte index is n.
  function automatic logic [7:0] utt_byte_at(input logic [CpW-1:0] cp,
                                             input logic [1:0] n,
                                             input logic [1:0] i);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (n)
      Len1: b = {1'b0, cp[6:0]};
      Len2: begin
        if (i == 2'd0) b = {3'b110, cp[10:6]};
        else           b = {2'b10, cp[5:0]};
      end
      Len3: begin
        case (i)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (i)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[sv/utt_unit_if.sv]
// Input channel: one UTF-16 code unit per word with an end-of-string flag.
// Depends on utt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface utt_unit_if
  import utt_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [UnitW-1:0] code_unit;
  logic             final_unit;

  modport source (output valid, output code_unit, output final_unit, input ready);
  modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface
`default_nettype wire

[sv/utt_byte_if.sv]
// Output channel: one UTF-8 byte per word with run and string end marks.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface utt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output out_byte, output run_last, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_done,
                  output ready);
endinterface
`default_nettype wire

[sv/utf16_to_utf8_transcoder.sv]
// Top level of the UTF-16 to UTF-8 transcoder: front end, queue, back end.
// Depends on utt_pkg, utt_unit_if, utt_byte_if, utt_front, utt_queue, utt_back.
//
//   channel  dir  words                       payload
//   units    in   one UTF-16 code unit        code_unit[15:0], final_unit
//   bytes    out  one UTF-8 byte              out_byte[7:0], run_last, string_done
//
// Bytes: each unit yields 0 to 4 bytes, one byte per cycle while bytes.ready is high,
//   decoded from the back end's held code point.
// The front end takes a unit every cycle the two-entry queue has room; a held
//   lead surrogate is taken in but pushes nothing.
// Reset (rst, synchronous) clears the held lead, the queue and the back end.
// A stall on bytes backs up into the queue and then drops units.ready; the
//   front keeps accepting while a finished byte waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module utf16_to_utf8_transcoder
  import utt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  utt_unit_if.sink   units,
  utt_byte_if.source bytes
);
  // Decoded code points flow front -> queue -> back.
  logic      push;
  logic      pop;
  cp_entry_t push_data;
  cp_entry_t pop_data;
  q_status_t q_stat;

  // Classify units, pair surrogates, size the sequence.
  utt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .units     (units),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple unit intake from byte emission.
  utt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // Emit the bytes of each code point in order, one per cycle while bytes.ready is high.
  utt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .bytes    (bytes)
  );
endmodule
`default_nettype wire

[sv/utt_queue.sv]
// Two-entry queue of decoded code points between front and back.
// Depends on utt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module utt_queue
  import utt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire cp_entry_t push_data,
  input  wire logic      pop,
  output cp_entry_t      pop_data,
  output q_status_t      stat
);
  cp_entry_t        mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == QCntW'(QDepth));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.full && push && !pop |=> stat.full)
    else $error("queue lost its full state on a blocked push");
endmodule
`default_nettype wire

[sv/utt_front.sv]
// Front end: accepts code units, pairs surrogates, sizes the UTF-8 sequence.
// Depends on utt_pkg and utt_unit_if.
`timescale 1ns / 1ps
`default_nettype none
module utt_front
  import utt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  utt_unit_if.sink       units,
  input  wire q_status_t q_stat,
  output logic           push,
  output cp_entry_t      push_data
);
  logic            lead_pending;
  logic [LowW-1:0] lead_bits;
  logic            take;
  logic            is_surr;
  logic            hold;
  logic [CpW-1:0]  cp;

  assign units.ready = !q_stat.full;
  assign take    = units.valid && units.ready;
  assign is_surr = (units.code_unit >= SurrLo) && (units.code_unit <= SurrHi);
  assign hold    = !lead_pending && is_surr && !units.final_unit;

  // Pairing: lead's low ten bits plus the plane offset sit above the unit's low ten bits.
  assign cp = lead_pending ? {(11'(lead_bits) + PlaneOfs), units.code_unit[LowW-1:0]}
                           : CpW'(units.code_unit);

  always_comb begin
    push_data.cp  = cp;
    push_data.fin = units.final_unit;
    if (cp < Lim1Byte)      push_data.n = Len1;
    else if (cp < Lim2Byte) push_data.n = Len2;
    else if (cp < Lim3Byte) push_data.n = Len3;
    else                    push_data.n = Len4;
  end

  assign push = take && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      lead_bits    <= '0;
    end else if (take) begin
      lead_pending <= hold;
      lead_bits    <= hold ? units.code_unit[LowW-1:0] : '0;
    end
  end

  a_pair_releases: assert property (@(posedge clk) disable iff (rst)
    take && lead_pending |=> !lead_pending)
    else $error("held lead survived its pairing unit");
  a_hold_sets: assert property (@(posedge clk) disable iff (rst)
    take && hold |=> lead_pending && !$past(push))
    else $error("held surrogate not registered or pushed");
endmodule
`default_nettype wire

[sv/utt_back.sv]
// Back end: serializes one queued code point into 1 to 4 UTF-8 bytes.
// Depends on utt_pkg and utt_byte_if.
`timescale 1ns / 1ps
`default_nettype none
module utt_back
  import utt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_status_t q_stat,
  input  wire cp_entry_t pop_data,
  output logic           pop,
  utt_byte_if.source     bytes
);
  logic      busy;
  cp_entry_t cur;
  logic [1:0] idx;
  logic      last;
  logic      sent;

  assign last              = (idx == cur.n);
  assign bytes.valid       = busy;
  assign bytes.out_byte    = utt_byte_at(cur.cp, cur.n, idx);
  assign bytes.run_last    = last;
  assign bytes.string_done = last && cur.fin;
  assign sent              = busy && bytes.ready;
  assign pop               = (!busy || (sent && last)) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (sent) begin
      if (last) busy <= 1'b0;
      idx <= idx + 1'b1;
    end
  end

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    sent && !last |=> bytes.valid && idx == $past(idx) + 2'd1)
    else $error("byte run broken before its last byte");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= cur.n)
    else $error("byte index beyond sequence length");
endmodule
`default_nettype wire

[tb/utt_checker.sv]
// Scoreboard for the UTF-16 to UTF-8 transcoder: watches both channels, predicts the bytes.
// Depends on utt_pkg, utt_unit_if and utt_byte_if; instantiated by tb.
`timescale 1ns / 1ps
module utt_checker
  import utt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  utt_unit_if  units,
  utt_byte_if  bytes,
  output int   fail_count,
  output int   bytes_owed
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } utf8_word_t;

  utf8_word_t      owed_words[$];
  logic            lead_held;
  logic [LowW-1:0] lead_low;

  // Queue the UTF-8 words that one accepted code unit produces.
  task automatic encode_unit(input logic [UnitW-1:0] unit, input logic fin);
    logic [CpW-1:0] cp;
    logic [7:0]     seq[4];
    int             cnt;
    utf8_word_t     w;
    if (lead_held) begin
      // Pair with whatever comes next, trail or not.
      cp = ((CpW'(lead_low) + CpW'(PlaneOfs)) << 10) + CpW'(unit[9:0]);
      lead_held = 1'b0;
      lead_low  = '0;
    end else if (unit >= SurrLo && unit <= SurrHi && !fin) begin
      lead_held = 1'b1;
      lead_low  = unit[9:0];
      return;
    end else begin
      cp = CpW'(unit);
    end
    if (cp < Lim1Byte) begin
      seq[0] = {1'b0, cp[6:0]};
      cnt = 1;
    end else if (cp < Lim2Byte) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      cnt = 2;
    end else if (cp < Lim3Byte) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      cnt = 3;
    end else begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      cnt = 4;
    end
    for (int i = 0; i < cnt; i++) begin
      w.out_byte    = seq[i];
      w.run_last    = (i == cnt - 1);
      w.string_done = (i == cnt - 1) && fin;
      owed_words.insert(owed_words.size(), w);
    end
  endtask

  initial begin
    fail_count = 0;
    bytes_owed = 0;
    lead_held  = 1'b0;
    lead_low   = '0;
  end

  always @(posedge clk) begin
    utf8_word_t w;
    if (rst) begin
      owed_words.delete();
      lead_held = 1'b0;
      lead_low  = '0;
    end else begin
      if (units.valid && units.ready) encode_unit(units.code_unit, units.final_unit);
      if (bytes.valid && bytes.ready) begin
        if (owed_words.size() == 0) begin
          $error("unexpected word: out_byte %h run_last %b string_done %b",
                 bytes.out_byte, bytes.run_last, bytes.string_done);
          fail_count++;
        end else begin
          w = owed_words.pop_front();
          if (bytes.out_byte !== w.out_byte) begin
            $error("out_byte: expected %h, got %h", w.out_byte, bytes.out_byte);
            fail_count++;
          end
          if (bytes.run_last !== w.run_last) begin
            $error("run_last: expected %b, got %b", w.run_last, bytes.run_last);
            fail_count++;
          end
          if (bytes.string_done !== w.string_done) begin
            $error("string_done: expected %b, got %b", w.string_done, bytes.string_done);
            fail_count++;
          end
        end
      end
    end
    bytes_owed = owed_words.size();
  end

endmodule

[tb/tb.sv]
// Testbench top for utf16_to_utf8_transcoder: clock, reset, unit stimulus, byte back-pressure.
// Depends on utt_pkg, utt_unit_if, utt_byte_if, the transcoder RTL and utt_checker.
`timescale 1ns / 1ps
module tb
  import utt_pkg::*;
  ;

  logic clk;
  logic rst;
  int   fail_count;
  int   bytes_owed;
  // Idle odds: 0 disables bubbles, otherwise roughly one bubble burst per that many words.
  int   idle_odds;
  int   random_units;

  utt_unit_if units_if ();
  utt_byte_if bytes_if ();

  utf16_to_utf8_transcoder u_top (
    .clk   (clk),
    .rst   (rst),
    .units (units_if),
    .bytes (bytes_if)
  );

  utt_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .units      (units_if),
    .bytes      (bytes_if),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or words go missing.
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

  // Known values on every input from time zero.
  initial begin
    rst                 = 1'b1;
    units_if.valid      = 1'b0;
    units_if.code_unit  = '0;
    units_if.final_unit = 1'b0;
    bytes_if.ready      = 1'b0;
    idle_odds           = 0;
    random_units        = 0;
  end

  // Byte side back-pressure: drop ready in random bursts while idling is on.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      bytes_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      bytes_if.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      bytes_if.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 8);
    end else begin
      bytes_if.ready <= 1'b1;
    end
  end

  // Present one code unit and hold it until the handshake. A bubble, when taken,
  // drops valid on one falling edge and raises it again on a later one.
  task automatic send_unit(input logic [UnitW-1:0] u, input logic fin);
    int gap;
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      units_if.valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    units_if.valid      <= 1'b1;
    units_if.code_unit  <= u;
    units_if.final_unit <= fin;
    do @(posedge clk); while (!units_if.ready);
  endtask

  // One random string. Mostly well-formed text across all encoding lengths,
  // with surrogate pairs; the rest is broken pairs, lone surrogates and noise.
  // The last unit always carries final_unit, so no lead is left held.
  task automatic send_random_string();
    int          len;
    int          k;
    logic [15:0] u;
    len = $urandom_range(1, 10);
    k   = 0;
    while (k < len) begin
      case ($urandom_range(0, 9))
        0, 1: u = 16'($urandom_range(16'h0000, 16'h007f));
        2:    u = 16'($urandom_range(16'h0080, 16'h07ff));
        3: begin
          if ($urandom_range(0, 1)) u = 16'($urandom_range(16'h0800, 16'hd7ff));
          else                      u = 16'($urandom_range(16'he000, 16'hffff));
        end
        4, 5, 6: begin
          // Well-formed pair: stretch the string so the trail fits.
          if (len < k + 2) len = k + 2;
          send_unit(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
          k++;
          random_units++;
          u = 16'($urandom_range(16'hdc00, 16'hdfff));
        end
        7: begin
          // Broken pair: a lead followed by any value at all.
          if (len < k + 2) len = k + 2;
          send_unit(16'($urandom_range(16'hd800, 16'hdfff)), 1'b0);
          k++;
          random_units++;
          u = 16'($urandom);
        end
        8:       u = 16'($urandom_range(16'hd800, 16'hdfff));
        default: u = 16'($urandom);
      endcase
      send_unit(u, k == len - 1);
      k++;
      random_units++;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: encoding boundaries, all-zero and all-one units, pairs at the
    // surrogate range edges, a lead paired with a non-trail or another lead,
    // and surrogates that end their string and so are encoded alone.
    idle_odds = 4;
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007f, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07ff, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hd7ff, 1'b0);
    send_unit(16'he000, 1'b0);
    send_unit(16'hffff, 1'b1);
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hdbff, 1'b0);
    send_unit(16'hdfff, 1'b1);
    send_unit(16'hd834, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdbff, 1'b1);
    send_unit(16'hdfff, 1'b0);
    send_unit(16'hffff, 1'b0);
    send_unit(16'hdc00, 1'b0);
    send_unit(16'h0000, 1'b1);
    send_unit(16'hdc00, 1'b1);
    send_unit(16'hdfff, 1'b1);
    send_unit(16'hd800, 1'b1);
    send_unit(16'h0000, 1'b1);

    // Random strings, phased: heavy idling, none, light idling, then a clean tail.
    while (random_units < 436) begin
      if (random_units < 150)      idle_odds = 3;
      else if (random_units < 230) idle_odds = 0;
      else if (random_units < 360) idle_odds = 6;
      else                         idle_odds = 0;
      send_random_string();
    end

    // Release valid and drain; the checker pushed the last expectations at
    // the final accepting edge, so it is safe to look on the falling edge.
    @(negedge clk);
    units_if.valid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
sv/utt_pkg.sv
sv/utt_unit_if.sv
sv/utt_byte_if.sv
sv/utt_queue.sv
sv/utt_front.sv
sv/utt_back.sv
sv/utf16_to_utf8_transcoder.sv
tb/utt_checker.sv
tb/tb.sv
